FILE: design/wsla_pkg.sv
// Shared widths and codes for the wheel slip and tank level alarm.
// No dependencies; used by wheel_slip_and_level_alarm.
`default_nettype none
package wsla_pkg;

    localparam int DIVIDEND_W = 32;
    localparam int STEP_W     = $clog2(DIVIDEND_W);
    localparam int SPEED_W    = 16;
    localparam int RATIO_W    = 4;
    localparam int LEVEL_W    = 8;
    localparam int PROD_W     = SPEED_W + RATIO_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STOP_W     = 2;
    localparam int WARN_W     = 3;
    localparam int OUT_W      = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_K   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_K  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLIP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REARM_THR = 3'd5;

    // register reset values
    localparam logic [RATIO_W-1:0] SLIP_RESET  = 4'd2;
    localparam logic [LEVEL_W-1:0] LOW_RESET   = 8'd3;
    localparam logic [LEVEL_W-1:0] REARM_RESET = 8'd15;

    // stop codes
    localparam logic [STOP_W-1:0] STOP_NONE   = 2'd0;
    localparam logic [STOP_W-1:0] STOP_FIRST  = 2'd1;
    localparam logic [STOP_W-1:0] STOP_SECOND = 2'd2;

    // warning codes
    localparam logic [WARN_W-1:0] WARN_NONE        = 3'd0;
    localparam logic [WARN_W-1:0] WARN_FIRST_SLIP  = 3'd1;
    localparam logic [WARN_W-1:0] WARN_SECOND_SLIP = 3'd2;
    localparam logic [WARN_W-1:0] WARN_RIGHT_LOW   = 3'd3;
    localparam logic [WARN_W-1:0] WARN_LEFT_LOW    = 3'd4;

endpackage
`default_nettype wire

FILE: design/wheel_slip_and_level_alarm.sv
// Wheel slip and tank level alarm: top level with its shared divider and sequencer.
// Depends on wsla_pkg.
`default_nettype none
//
// Channel   Dir  Handshake                Payload
// --------  ---  -----------------------  ------------------------------------------
// s_axis    in   s_tvalid / s_tready      periods and tank levels
// m_axis    out  m_tvalid / m_tready      stop code, warning code
// cfg       in   cfg_valid / cfg_ready    register index, write data
//
// Sequence: with speed checking on, an accepted item goes through two 32-step
// restoring divisions on one shared subtract/compare unit, then a final step for
// the slip compare and level latches; with it off, it goes straight to that step.
// Reset clears the sequencer, the level latches and loads the register defaults.
// A result waits in the output register while the next item is accepted; the
// sequencer holds in its final step only if the previous result is still untaken.
// The configuration channel is always ready.
//
module wheel_slip_and_level_alarm #(
    parameter int FIRST_PERIOD_BITS  = 16,
    parameter int SECOND_PERIOD_BITS = 8
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    // slave stream
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    // tdata, low bit up: first_period, second_period, left_level, right_level, zero pad
    input  wire logic [((FIRST_PERIOD_BITS + SECOND_PERIOD_BITS + 2 * wsla_pkg::LEVEL_W
                          + 7) / 8) * 8 - 1:0]        s_tdata,
    // master stream
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    // tdata, low bit up: stop_code[1:0], warning_code[4:2], zero pad
    output logic [wsla_pkg::OUT_W-1:0]                   m_tdata,
    // configuration write channel
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [wsla_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [wsla_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int F_W   = FIRST_PERIOD_BITS;
    localparam int S_W   = SECOND_PERIOD_BITS;
    localparam int L_W   = wsla_pkg::LEVEL_W;
    // shared divisor / remainder width
    localparam int DIV_W = (F_W > S_W) ? F_W : S_W;
    localparam int LEFT_LO  = F_W + S_W;
    localparam int RIGHT_LO = F_W + S_W + L_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } state_t;

    // ---------------------------------------------------------------- config
    logic                              speed_en_reg;
    logic [wsla_pkg::DIVIDEND_W-1:0]   first_k_reg;
    logic [wsla_pkg::DIVIDEND_W-1:0]   second_k_reg;
    logic [wsla_pkg::RATIO_W-1:0]      slip_reg;
    logic [L_W-1:0]                    low_thr_reg;
    logic [L_W-1:0]                    rearm_thr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_en_reg  <= 1'b0;
            first_k_reg   <= '0;
            second_k_reg  <= '0;
            slip_reg      <= wsla_pkg::SLIP_RESET;
            low_thr_reg   <= wsla_pkg::LOW_RESET;
            rearm_thr_reg <= wsla_pkg::REARM_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                wsla_pkg::REG_SPEED_EN:  speed_en_reg  <= cfg_data[0];
                wsla_pkg::REG_FIRST_K:   first_k_reg   <= cfg_data;
                wsla_pkg::REG_SECOND_K:  second_k_reg  <= cfg_data;
                wsla_pkg::REG_SLIP:      slip_reg      <= cfg_data[wsla_pkg::RATIO_W-1:0];
                wsla_pkg::REG_LOW_THR:   low_thr_reg   <= cfg_data[L_W-1:0];
                wsla_pkg::REG_REARM_THR: rearm_thr_reg <= cfg_data[L_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------- datapath state
    state_t                              state_reg, state_next;
    logic [F_W-1:0]                      p1_reg, p1_next;
    logic [S_W-1:0]                      p2_reg, p2_next;
    logic [L_W-1:0]                      left_reg, left_next;
    logic [L_W-1:0]                      right_reg, right_next;
    logic                                sel_reg, sel_next;     // 0: first wheel, 1: second
    logic [wsla_pkg::STEP_W-1:0]         cnt_reg, cnt_next;
    logic [wsla_pkg::DIVIDEND_W-1:0]     quo_reg, quo_next;     // dividend shifts out, quotient in
    logic [DIV_W-1:0]                    rem_reg, rem_next;
    logic [wsla_pkg::SPEED_W-1:0]        v1_reg, v1_next;
    logic [wsla_pkg::SPEED_W-1:0]        v2_reg, v2_next;
    logic                                rlow_reg, rlow_next;
    logic                                llow_reg, llow_next;
    logic                                out_valid_reg, out_valid_next;
    logic [wsla_pkg::STOP_W-1:0]         out_stop_reg, out_stop_next;
    logic [wsla_pkg::WARN_W-1:0]         out_warn_reg, out_warn_next;

    // ---------------------------------------------------------------- shared divide step
    // Restoring step. A zero divisor always passes the compare, so the quotient
    // comes out all ones and its low half is the saturated speed 65535.
    logic [DIV_W-1:0]   divisor;
    logic [DIV_W:0]     rem_shift;
    logic [DIV_W:0]     rem_diff;
    logic               q_bit;

    assign divisor   = sel_reg ? DIV_W'(p2_reg) : DIV_W'(p1_reg);
    assign rem_shift = {rem_reg, quo_reg[wsla_pkg::DIVIDEND_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, divisor});
    assign rem_diff  = rem_shift - {1'b0, divisor};

    // ---------------------------------------------------------------- result logic
    logic                           stop1, stop2;
    logic [wsla_pkg::STOP_W-1:0]    stop_code;
    logic [wsla_pkg::PROD_W-1:0]    lim1, lim2;
    logic [wsla_pkg::WARN_W-1:0]    slip_warn;

    assign stop1 = (p1_reg == {F_W{1'b1}});
    assign stop2 = (p2_reg == {S_W{1'b1}});

    always_comb
    begin
        if (stop1 && !stop2)
            stop_code = wsla_pkg::STOP_FIRST;
        else if (stop2 && !stop1)
            stop_code = wsla_pkg::STOP_SECOND;
        else
            stop_code = wsla_pkg::STOP_NONE;
    end

    // ratio times speed, full width
    assign lim1 = wsla_pkg::PROD_W'(slip_reg) * wsla_pkg::PROD_W'(v1_reg);
    assign lim2 = wsla_pkg::PROD_W'(slip_reg) * wsla_pkg::PROD_W'(v2_reg);

    always_comb
    begin
        slip_warn = wsla_pkg::WARN_NONE;
        if (speed_en_reg)
        begin
            if (wsla_pkg::PROD_W'(v2_reg) > lim1)
                slip_warn = wsla_pkg::WARN_FIRST_SLIP;
            else if (wsla_pkg::PROD_W'(v1_reg) > lim2)
                slip_warn = wsla_pkg::WARN_SECOND_SLIP;
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next     = state_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        sel_next       = sel_reg;
        cnt_next       = cnt_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        v1_next        = v1_reg;
        v2_next        = v2_reg;
        rlow_next      = rlow_reg;
        llow_next      = llow_reg;
        out_valid_next = out_valid_reg;
        out_stop_next  = out_stop_reg;
        out_warn_next  = out_warn_reg;

        // result taken
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    p1_next    = s_tdata[F_W-1:0];
                    p2_next    = s_tdata[F_W +: S_W];
                    left_next  = s_tdata[LEFT_LO +: L_W];
                    right_next = s_tdata[RIGHT_LO +: L_W];
                    sel_next   = 1'b0;
                    cnt_next   = wsla_pkg::STEP_W'(wsla_pkg::DIVIDEND_W - 1);
                    quo_next   = first_k_reg;
                    rem_next   = '0;
                    state_next = speed_en_reg ? ST_DIV : ST_FINISH;
                end
            end

            ST_DIV:
            begin
                rem_next = q_bit ? rem_diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
                quo_next = {quo_reg[wsla_pkg::DIVIDEND_W-2:0], q_bit};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    if (!sel_reg)
                    begin
                        v1_next  = quo_next[wsla_pkg::SPEED_W-1:0];
                        sel_next = 1'b1;
                        cnt_next = wsla_pkg::STEP_W'(wsla_pkg::DIVIDEND_W - 1);
                        quo_next = second_k_reg;
                        rem_next = '0;
                    end
                    else
                    begin
                        v2_next    = quo_next[wsla_pkg::SPEED_W-1:0];
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_stop_next  = stop_code;
                    out_warn_next  = slip_warn;
                    if (slip_warn == wsla_pkg::WARN_NONE)
                    begin
                        if (right_reg < low_thr_reg && !rlow_reg)
                        begin
                            rlow_next     = 1'b1;
                            out_warn_next = wsla_pkg::WARN_RIGHT_LOW;
                        end
                        else if (left_reg < low_thr_reg && !llow_reg)
                        begin
                            llow_next     = 1'b1;
                            out_warn_next = wsla_pkg::WARN_LEFT_LOW;
                        end
                        else
                        begin
                            // rearm only on a quiet item
                            if (right_reg >= rearm_thr_reg)
                                rlow_next = 1'b0;
                            if (left_reg >= rearm_thr_reg)
                                llow_next = 1'b0;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            p1_reg        <= '0;
            p2_reg        <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            sel_reg       <= 1'b0;
            cnt_reg       <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            v1_reg        <= '0;
            v2_reg        <= '0;
            rlow_reg      <= 1'b0;
            llow_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_stop_reg  <= wsla_pkg::STOP_NONE;
            out_warn_reg  <= wsla_pkg::WARN_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            p1_reg        <= p1_next;
            p2_reg        <= p2_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            quo_reg       <= quo_next;
            rem_reg       <= rem_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            rlow_reg      <= rlow_next;
            llow_reg      <= llow_next;
            out_valid_reg <= out_valid_next;
            out_stop_reg  <= out_stop_next;
            out_warn_reg  <= out_warn_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(wsla_pkg::OUT_W - wsla_pkg::STOP_W - wsla_pkg::WARN_W){1'b0}},
                       out_warn_reg, out_stop_reg};

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for wheel_slip_and_level_alarm: directed table, then random phases.
// Depends on wsla_pkg and the wheel_slip_and_level_alarm RTL; needs no other file.
`default_nettype none
module tb;

    // ------------------------------------------------------------------
    // Run limits
    // ------------------------------------------------------------------
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASES        = 14;
    localparam int READINGS_EACH = 120;         // readings per random phase
    localparam int DRAIN_CYCLES  = 80;          // longer than one full speed-check pass
    localparam int LONG_HOLD     = 600;         // receiver hold-off, in cycles

    // Register indexes with no register behind them; writes there must be ignored
    localparam logic [wsla_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [wsla_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [wsla_pkg::STOP_W-1:0] stop;
        logic [wsla_pkg::WARN_W-1:0] warn;
    } alarm_t;

    typedef enum logic [1:0] {ROW_WRITE, ROW_FIXED, ROW_PREDICTED} row_kind_t;

    typedef struct {
        row_kind_t                        kind;
        logic [wsla_pkg::CFG_IDX_W-1:0]   idx;
        logic [wsla_pkg::CFG_DATA_W-1:0]  data;
        logic [15:0]                      p_first;
        logic [7:0]                       p_second;
        logic [wsla_pkg::LEVEL_W-1:0]     lvl_left;
        logic [wsla_pkg::LEVEL_W-1:0]     lvl_right;
        logic [wsla_pkg::STOP_W-1:0]      stop;
        logic [wsla_pkg::WARN_W-1:0]      warn;
    } row_t;

    // ------------------------------------------------------------------
    // DUT connections; every input holds a known value from time zero
    // ------------------------------------------------------------------
    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    // tdata, low bit up: first_period, second_period, left_level, right_level
    logic [39:0]                      s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    // tdata, low bit up: stop_code[1:0], warning_code[4:2], zero pad
    logic [wsla_pkg::OUT_W-1:0]       m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [wsla_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [wsla_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    wheel_slip_and_level_alarm #(
        .FIRST_PERIOD_BITS  (16),
        .SECOND_PERIOD_BITS (8)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the alarm: register copies and the two low-level latches
    // ------------------------------------------------------------------
    logic                           sh_speed_en    = 1'b0;
    logic [31:0]                    sh_k_first     = '0;
    logic [31:0]                    sh_k_second    = '0;
    logic [wsla_pkg::RATIO_W-1:0]   sh_slip        = wsla_pkg::SLIP_RESET;
    logic [wsla_pkg::LEVEL_W-1:0]   sh_low_thr     = wsla_pkg::LOW_RESET;
    logic [wsla_pkg::LEVEL_W-1:0]   sh_rearm_thr   = wsla_pkg::REARM_RESET;
    logic                           sh_right_latch = 1'b0;
    logic                           sh_left_latch  = 1'b0;

    alarm_t pending_alarms[$];
    int     errors = 0;
    int     cycles = 0;
    int     hold_req = 0;      // set by the stimulus, picked up by the receiver
    int     burst_left = 0;
    bit     cfg_open = 1'b0;
    row_t   plan[$];

    // Register write as the block sees it: narrow registers keep their low bits only
    function automatic void shadow_write(input logic [wsla_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [wsla_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            wsla_pkg::REG_SPEED_EN:  sh_speed_en  = data[0];
            wsla_pkg::REG_FIRST_K:   sh_k_first   = data;
            wsla_pkg::REG_SECOND_K:  sh_k_second  = data;
            wsla_pkg::REG_SLIP:      sh_slip      = data[wsla_pkg::RATIO_W-1:0];
            wsla_pkg::REG_LOW_THR:   sh_low_thr   = data[wsla_pkg::LEVEL_W-1:0];
            wsla_pkg::REG_REARM_THR: sh_rearm_thr = data[wsla_pkg::LEVEL_W-1:0];
            default:                 ;
        endcase
    endfunction

    // Speed = dividend / period, low 16 bits; a zero period saturates
    function automatic logic [wsla_pkg::SPEED_W-1:0] wheel_speed(input logic [31:0] k,
                                                                 input logic [15:0] period);
        logic [31:0] q;
        if (period == 16'd0)
            return {wsla_pkg::SPEED_W{1'b1}};
        q = k / {16'd0, period};
        return q[wsla_pkg::SPEED_W-1:0];
    endfunction

    // Alarm for one reading; updates the latches as the block would
    function automatic alarm_t alarm_for_reading(input logic [15:0] p_first,
                                                 input logic [7:0] p_second,
                                                 input logic [wsla_pkg::LEVEL_W-1:0] lvl_left,
                                                 input logic [wsla_pkg::LEVEL_W-1:0] lvl_right);
        alarm_t                         a;
        logic                           stopped_1;
        logic                           stopped_2;
        logic [wsla_pkg::SPEED_W-1:0]   v1;
        logic [wsla_pkg::SPEED_W-1:0]   v2;
        logic [wsla_pkg::PROD_W-1:0]    lim1;
        logic [wsla_pkg::PROD_W-1:0]    lim2;
        stopped_1 = (p_first == 16'hFFFF);
        stopped_2 = (p_second == 8'hFF);
        a.stop = wsla_pkg::STOP_NONE;
        a.warn = wsla_pkg::WARN_NONE;
        if (stopped_1 && !stopped_2)
            a.stop = wsla_pkg::STOP_FIRST;
        else if (stopped_2 && !stopped_1)
            a.stop = wsla_pkg::STOP_SECOND;
        if (sh_speed_en)
        begin
            v1   = wheel_speed(sh_k_first, p_first);
            v2   = wheel_speed(sh_k_second, {8'd0, p_second});
            // full-width products, ratio up to 15 never wraps in 20 bits
            lim1 = {{(wsla_pkg::PROD_W-wsla_pkg::RATIO_W){1'b0}}, sh_slip}
                   * {{wsla_pkg::RATIO_W{1'b0}}, v1};
            lim2 = {{(wsla_pkg::PROD_W-wsla_pkg::RATIO_W){1'b0}}, sh_slip}
                   * {{wsla_pkg::RATIO_W{1'b0}}, v2};
            if ({{wsla_pkg::RATIO_W{1'b0}}, v2} > lim1)
                a.warn = wsla_pkg::WARN_FIRST_SLIP;
            else if ({{wsla_pkg::RATIO_W{1'b0}}, v1} > lim2)
                a.warn = wsla_pkg::WARN_SECOND_SLIP;
        end
        // level warnings only when no slip; rearm only when nothing warns
        if (a.warn == wsla_pkg::WARN_NONE)
        begin
            if (lvl_right < sh_low_thr && !sh_right_latch)
            begin
                sh_right_latch = 1'b1;
                a.warn = wsla_pkg::WARN_RIGHT_LOW;
            end
            else if (lvl_left < sh_low_thr && !sh_left_latch)
            begin
                sh_left_latch = 1'b1;
                a.warn = wsla_pkg::WARN_LEFT_LOW;
            end
            else
            begin
                if (lvl_right >= sh_rearm_thr)
                    sh_right_latch = 1'b0;
                if (lvl_left >= sh_rearm_thr)
                    sh_left_latch = 1'b0;
            end
        end
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One reading on the slave stream; senders come in bursts with random gaps.
    // The expected alarm is queued at the accepting edge.
    task automatic send_reading(input logic [15:0] p_first, input logic [7:0] p_second,
                                input logic [wsla_pkg::LEVEL_W-1:0] lvl_left,
                                input logic [wsla_pkg::LEVEL_W-1:0] lvl_right,
                                input bit fixed, input alarm_t typed);
        int     gap;
        alarm_t predicted;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {lvl_right, lvl_left, p_second, p_first};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        predicted = alarm_for_reading(p_first, p_second, lvl_left, lvl_right);
        pending_alarms.push_back(fixed ? typed : predicted);
    endtask

    // Stop offering and wait until every queued alarm has been taken
    task automatic settle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_alarms.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One config transaction; cfg_valid stays up for back-to-back writes
    task automatic write_register(input logic [wsla_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [wsla_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_write(idx, data);
    endtask

    task automatic add_cfg(input logic [wsla_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wsla_pkg::CFG_DATA_W-1:0] data);
        row_t r;
        r.kind      = ROW_WRITE;
        r.idx       = idx;
        r.data      = data;
        r.p_first   = '0;
        r.p_second  = '0;
        r.lvl_left  = '0;
        r.lvl_right = '0;
        r.stop      = '0;
        r.warn      = '0;
        plan.push_back(r);
    endtask

    task automatic add_reading(input row_kind_t kind, input logic [15:0] p1,
                               input logic [7:0] p2, input logic [7:0] lvl_l,
                               input logic [7:0] lvl_r,
                               input logic [wsla_pkg::STOP_W-1:0] stop,
                               input logic [wsla_pkg::WARN_W-1:0] warn);
        row_t r;
        r.kind      = kind;
        r.idx       = '0;
        r.data      = '0;
        r.p_first   = p1;
        r.p_second  = p2;
        r.lvl_left  = lvl_l;
        r.lvl_right = lvl_r;
        r.stop      = stop;
        r.warn      = warn;
        plan.push_back(r);
    endtask

    // Periods: saturating zero, stopped all-ones, short and long periods
    function automatic logic [15:0] pick_period(input bit narrow);
        logic [15:0] p;
        case ($urandom_range(0, 7))
            0:       p = 16'd0;
            1:       p = 16'hFFFF;
            2:       p = 16'($urandom_range(1, 16));
            3:       p = 16'($urandom_range(1, 255));
            default: p = 16'($urandom_range(0, 65535));
        endcase
        if (narrow)
            p[15:8] = 8'd0;
        return p;
    endfunction

    // Levels: extremes, random values, and values close to the two thresholds so the latches keep moving
    function automatic logic [wsla_pkg::LEVEL_W-1:0] pick_level();
        int v;
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 255;
            2:       v = int'(sh_low_thr) + int'($urandom_range(0, 4)) - 2;
            3:       v = int'(sh_rearm_thr) + int'($urandom_range(0, 4)) - 2;
            default: v = $urandom_range(0, 255);
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return wsla_pkg::LEVEL_W'(v);
    endfunction

    function automatic logic [31:0] pick_dividend();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom();
            3:       return 32'($urandom_range(0, 65535));
            default: return 32'($urandom_range(0, 32'h00FF_FFFF));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own, plus a long hold-off on request
    // ------------------------------------------------------------------
    int hold_left = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req > 0)
        begin
            hold_left <= hold_req;
            hold_req  = 0;
            m_tready  <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(5, 80);
            end
            rx_mode_left = rx_mode_left - 1;
            case (rx_mode)
                0:       m_tready <= 1'b1;                      // no stalls
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result check against the oldest queued alarm
    // ------------------------------------------------------------------
    alarm_t want;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_alarms.size() == 0)
            begin
                $error("alarm transaction with nothing expected: m_tdata=%h", m_tdata);
                errors++;
            end
            else
            begin
                want = pending_alarms.pop_front();
                if (m_tdata[1:0] !== want.stop)
                begin
                    $error("stop_code: expected %0d, got %0d", want.stop, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[4:2] !== want.warn)
                begin
                    $error("warning_code: expected %0d, got %0d", want.warn, m_tdata[4:2]);
                    errors++;
                end
                if (m_tdata[wsla_pkg::OUT_W-1:5] !== '0)
                begin
                    $error("m_tdata pad: expected 0, got %0h", m_tdata[wsla_pkg::OUT_W-1:5]);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("wheel_slip_and_level_alarm regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        logic                           en;
        logic [wsla_pkg::RATIO_W-1:0]   ratio;
        logic [wsla_pkg::LEVEL_W-1:0]   low_thr;
        logic [wsla_pkg::LEVEL_W-1:0]   rearm_thr;
        logic [31:0]                    k1;
        logic [31:0]                    k2;
        bit                             narrow;
        alarm_t                         typed;

        // Directed table. Reset defaults: checking off, ratio 2, low 3, rearm 15.
        add_reading(ROW_FIXED, 16'hFFFF, 8'h00, 8'd100, 8'd100,
                    wsla_pkg::STOP_FIRST, wsla_pkg::WARN_NONE);
        add_reading(ROW_FIXED, 16'h0000, 8'hFF, 8'd100, 8'd100,
                    wsla_pkg::STOP_SECOND, wsla_pkg::WARN_NONE);
        // both stopped gives no stop code
        add_reading(ROW_FIXED, 16'hFFFF, 8'hFF, 8'd100, 8'd100,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_NONE);
        // both tanks empty: right first, then left, then both latched
        add_reading(ROW_FIXED, 16'h0000, 8'h00, 8'd0, 8'd0,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_RIGHT_LOW);
        add_reading(ROW_FIXED, 16'h0000, 8'h00, 8'd0, 8'd0,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_LEFT_LOW);
        add_reading(ROW_FIXED, 16'h0000, 8'h00, 8'd0, 8'd0,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_NONE);
        add_reading(ROW_FIXED, 16'h1234, 8'h56, 8'd255, 8'd255,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_NONE);
        // stop and warning together
        add_reading(ROW_FIXED, 16'hFFFF, 8'h00, 8'd255, 8'd2,
                    wsla_pkg::STOP_FIRST, wsla_pkg::WARN_RIGHT_LOW);
        // right exactly at the low threshold does not warn
        add_reading(ROW_FIXED, 16'h0000, 8'h00, 8'd2, 8'd3,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_LEFT_LOW);
        // left rearms at exactly 15, right at 14 stays latched
        add_reading(ROW_FIXED, 16'h0000, 8'h00, 8'd15, 8'd14,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_NONE);
        add_reading(ROW_FIXED, 16'h0000, 8'h00, 8'd0, 8'd0,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_LEFT_LOW);
        add_reading(ROW_FIXED, 16'h0000, 8'h00, 8'd255, 8'd15,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_NONE);
        // checking on, largest dividends, ratio zero (upper data bits must be dropped)
        add_cfg(wsla_pkg::REG_SPEED_EN, 32'h0000_0001);
        add_cfg(wsla_pkg::REG_FIRST_K, 32'hFFFF_FFFF);
        add_cfg(wsla_pkg::REG_SECOND_K, 32'hFFFF_FFFF);
        add_cfg(wsla_pkg::REG_SLIP, 32'hFFFF_FFF0);
        add_cfg(REG_SPARE_A, 32'hFFFF_FFFF);
        add_cfg(REG_SPARE_B, 32'h0000_0000);
        // both speeds saturate; with ratio zero any nonzero second speed gives a first slip
        add_reading(ROW_FIXED, 16'h0000, 8'h00, 8'd255, 8'd255,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_FIRST_SLIP);
        add_reading(ROW_PREDICTED, 16'hFFFF, 8'hFF, 8'd0, 8'd0,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_NONE);
        add_cfg(wsla_pkg::REG_SLIP, 32'h0000_000F);
        add_cfg(wsla_pkg::REG_FIRST_K, 32'h0001_0000);
        add_reading(ROW_PREDICTED, 16'h0001, 8'hFF, 8'd0, 8'd0,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_NONE);
        add_reading(ROW_PREDICTED, 16'h0100, 8'h01, 8'd0, 8'd0,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_NONE);
        add_reading(ROW_PREDICTED, 16'hFFFF, 8'h10, 8'd255, 8'd0,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_NONE);
        // checking off via bit 0 only; thresholds at their extremes
        add_cfg(wsla_pkg::REG_SPEED_EN, 32'hFFFF_FFFE);
        add_cfg(wsla_pkg::REG_LOW_THR, 32'h0000_00FF);
        add_cfg(wsla_pkg::REG_REARM_THR, 32'h0000_0000);
        add_reading(ROW_FIXED, 16'h0000, 8'h00, 8'd254, 8'd254,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_RIGHT_LOW);
        add_reading(ROW_FIXED, 16'h0000, 8'h00, 8'd255, 8'd254,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_NONE);
        add_reading(ROW_FIXED, 16'h0000, 8'h00, 8'd0, 8'd0,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_RIGHT_LOW);
        add_cfg(wsla_pkg::REG_LOW_THR, 32'hFFFF_FF00);
        add_cfg(wsla_pkg::REG_REARM_THR, 32'h0000_00FF);
        add_reading(ROW_FIXED, 16'h0000, 8'h00, 8'd0, 8'd0,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_NONE);
        add_reading(ROW_FIXED, 16'hFFFE, 8'hFE, 8'd255, 8'd255,
                    wsla_pkg::STOP_NONE, wsla_pkg::WARN_NONE);

        // Reset held low from time zero, released once
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                if (!cfg_open)
                begin
                    settle();
                    cfg_open = 1'b1;
                end
                write_register(plan[i].idx, plan[i].data);
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                typed.stop = plan[i].stop;
                typed.warn = plan[i].warn;
                send_reading(plan[i].p_first, plan[i].p_second, plan[i].lvl_left,
                             plan[i].lvl_right, plan[i].kind == ROW_FIXED, typed);
            end
        end

        // Random phases: the first four set chosen register values, among them the extremes
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    en = 1'b1; k1 = 32'hFFFF_FFFF; k2 = 32'hFFFF_FFFF;
                    ratio = 4'd15; low_thr = 8'd255; rearm_thr = 8'd255;
                end
                1:
                begin
                    en = 1'b1; k1 = 32'd0; k2 = 32'd0;
                    ratio = 4'd1; low_thr = 8'd0; rearm_thr = 8'd0;
                end
                2:
                begin
                    en = 1'b1; k1 = 32'h00FF_FFFF; k2 = 32'h0000_FFFF;
                    ratio = 4'd0; low_thr = 8'd128; rearm_thr = 8'd200;
                end
                3:
                begin
                    en = 1'b0; k1 = $urandom(); k2 = $urandom();
                    ratio = 4'd2; low_thr = 8'd255; rearm_thr = 8'd0;
                end
                default:
                begin
                    en        = 1'($urandom_range(0, 1));
                    k1        = pick_dividend();
                    k2        = pick_dividend();
                    ratio     = 4'($urandom_range(0, 15));
                    low_thr   = 8'($urandom_range(0, 255));
                    rearm_thr = 8'($urandom_range(0, 255));
                end
            endcase

            settle();
            // narrow registers get junk in their upper data bits
            write_register(wsla_pkg::REG_SPEED_EN,
                           ($urandom() & 32'hFFFF_FFFE) | {31'd0, en});
            write_register(wsla_pkg::REG_FIRST_K, k1);
            write_register(wsla_pkg::REG_SECOND_K, k2);
            write_register(wsla_pkg::REG_SLIP,
                           ($urandom() & 32'hFFFF_FFF0) | {28'd0, ratio});
            write_register(wsla_pkg::REG_LOW_THR,
                           ($urandom() & 32'hFFFF_FF00) | {24'd0, low_thr});
            write_register(wsla_pkg::REG_REARM_THR,
                           ($urandom() & 32'hFFFF_FF00) | {24'd0, rearm_thr});
            if ($urandom_range(0, 2) == 0)
                write_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom());
            cfg_valid <= 1'b0;

            // block fills up behind a stalled receiver while the sender keeps offering
            if (ph == 0)
                hold_req = LONG_HOLD;

            // short periods on both wheels keep speeds comparable in some phases
            narrow = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < READINGS_EACH; n++)
            begin
                if (ph == 2 && n == READINGS_EACH / 2)
                    settle();
                send_reading(pick_period(narrow), 8'(pick_period(1'b1)), pick_level(),
                             pick_level(), 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_alarms.size() != 0)
        begin
            $error("%0d alarms never arrived", pending_alarms.size());
            errors++;
        end
        if (errors == 0)
            $display("wheel_slip_and_level_alarm regression: pass");
        else
            $display("wheel_slip_and_level_alarm regression: fail");
        $finish;
    end

endmodule
`default_nettype wire

FILE: wheel_slip_and_level_alarm.f
design/wsla_pkg.sv
design/wheel_slip_and_level_alarm.sv
tb/sv/tb.sv
